// ----- rtl/ins_pkg.sv -----
// Shared types and constants for the insertion sorter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ins_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueW       = 32;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert; // place the broadcast value into the sorted row
    logic drain;  // move every entry one cell toward the output
  } cell_ctl_t;

endpackage : ins_pkg

`default_nettype wire

// ----- rtl/ins_cell.sv -----
// One cell of the sorting chain: holds one entry and its occupied bit.
// Depends on ins_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ins_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire ins_pkg::cell_ctl_t          ctl_i,
  input  wire signed [ins_pkg::ValueW-1:0] new_value_i,
  input  wire signed [ins_pkg::ValueW-1:0] left_value_i,
  input  wire                              left_occ_i,
  input  wire                              left_move_i,
  input  wire signed [ins_pkg::ValueW-1:0] right_value_i,
  input  wire                              right_occ_i,
  output logic signed [ins_pkg::ValueW-1:0] value_o,
  output logic                             occ_o,
  output logic                             move_o
);
  import ins_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;
  logic                     occ_q, occ_d;

  // Strict less-than keeps equal values in arrival order
  assign move_o = occ_q && (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    occ_d   = occ_q;
    if (ctl_i.drain) begin
      value_d = right_value_i;
      occ_d   = right_occ_i;
    end else if (ctl_i.insert) begin
      if (left_move_i) begin
        value_d = left_value_i;
        occ_d   = 1'b1;
      end else if (move_o || (!occ_q && left_occ_i)) begin
        value_d = new_value_i;
        occ_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign occ_o   = occ_q;

endmodule : ins_cell

`default_nettype wire

// ----- rtl/insertion_sorter.sv -----
// Top level of the insertion sorter: control and a row of ins_cell.
// Depends on ins_pkg and ins_cell.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o | value_i, final_item_i
//  out     | output    | out_valid_o / out_stall_i | sorted_value_o, is_last_o, overflowed_o
//
// Collecting: one value per cycle; each cell compares against the broadcast value
// and the row shifts right behind it in that same cycle.
// Draining: N results (N = entries held, 1..DEPTH), one row shift per unstalled cycle;
// the input is stalled from the final transfer until the last result leaves.
// Reset clears the occupied bits, the overflow flag and the drain mode; no sweep.
// Output stalls simply hold the row.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter #(
  parameter int unsigned DEPTH = ins_pkg::DepthDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire signed [ins_pkg::ValueW-1:0] value_i,
  input  wire                              final_item_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic signed [ins_pkg::ValueW-1:0] sorted_value_o,
  output logic                             is_last_o,
  output logic                             overflowed_o
);
  import ins_pkg::*;

  logic signed [ValueW-1:0] cell_value [DEPTH];
  logic                     cell_occ   [DEPTH];
  logic                     cell_move  [DEPTH];

  logic      draining_q, draining_d;
  logic      overflow_q, overflow_d;
  logic      in_xfer, out_xfer, full;
  cell_ctl_t ctl;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign full     = cell_occ[DEPTH-1];

  always_comb begin
    ctl.insert = in_xfer && !full;
    ctl.drain  = out_xfer;
  end

  always_comb begin
    draining_d = draining_q;
    overflow_d = overflow_q;
    if (in_xfer) begin
      if (full) overflow_d = 1'b1;
      if (final_item_i) draining_d = 1'b1;
    end
    if (out_xfer && is_last_o) begin
      draining_d = 1'b0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      draining_q <= draining_d;
      overflow_q <= overflow_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] left_value, right_value;
    logic                     left_occ, left_move, right_occ;

    if (i == 0) begin : g_head
      assign left_value = value_i;
      assign left_occ   = 1'b1;
      assign left_move  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_occ   = cell_occ[i-1];
      assign left_move  = cell_move[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_occ   = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_occ   = cell_occ[i+1];
    end

    ins_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_value_i  (value_i),
      .left_value_i (left_value),
      .left_occ_i   (left_occ),
      .left_move_i  (left_move),
      .right_value_i(right_value),
      .right_occ_i  (right_occ),
      .value_o      (cell_value[i]),
      .occ_o        (cell_occ[i]),
      .move_o       (cell_move[i])
    );
  end

  assign in_stall_o     = draining_q;
  assign out_valid_o    = draining_q;
  assign sorted_value_o = cell_value[0];
  assign is_last_o      = !cell_occ[1];
  assign overflowed_o   = overflow_q;

endmodule : insertion_sorter

`default_nettype wire

// ----- rtl/ins_checker.sv -----
// Port-level checks for insertion_sorter, bound to the top level.
// Depends on ins_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ins_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_stall_o,
  input wire signed [ins_pkg::ValueW-1:0] value_i,
  input wire                              final_item_i,
  input wire                              out_valid_o,
  input wire                              out_stall_i,
  input wire signed [ins_pkg::ValueW-1:0] sorted_value_o,
  input wire                              is_last_o,
  input wire                              overflowed_o
);
  import ins_pkg::*;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // no new input while a batch is being emitted
  a_stall_during_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during drain");

  a_final_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && final_item_i) |=> out_valid_o)
    else $error("final transfer did not start output");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !is_last_o) |=> (out_valid_o && sorted_value_o >= $past(sorted_value_o)
                                  && overflowed_o == $past(overflowed_o)))
    else $error("run broken, out of order or flag changed");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && is_last_o) |=> (!out_valid_o && !overflowed_o))
    else $error("output continued past last result");

endmodule : ins_checker

bind insertion_sorter ins_checker u_ins_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .value_i       (value_i),
  .final_item_i  (final_item_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sorted_value_o(sorted_value_o),
  .is_last_o     (is_last_o),
  .overflowed_o  (overflowed_o)
);

`default_nettype wire

// ----- test/insertion_sorter_test.sv -----
// Self-checking testbench for insertion_sorter: batches of signed values in,
// sorted runs out, checked against a local copy of the sorted store.
// Depends on ins_pkg and the insertion_sorter RTL.
`timescale 1ns / 1ps

module insertion_sorter_test;
  import ins_pkg::*;

  localparam int unsigned DEPTH     = DepthDefault;
  localparam int unsigned LongHold  = 400;
  localparam int unsigned CycleCap  = 200000;
  localparam int unsigned DrainWait = DEPTH + 20;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic                     is_final;
  } batch_item_t;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic                     is_last;
    logic                     overflowed;
  } sorted_out_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic signed [ValueW-1:0] value_i        = '0;
  logic                     final_item_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic signed [ValueW-1:0] sorted_value_o;
  logic                     is_last_o;
  logic                     overflowed_o;

  insertion_sorter dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .value_i,
    .final_item_i,
    .out_valid_o,
    .out_stall_i,
    .sorted_value_o,
    .is_last_o,
    .overflowed_o
  );

  batch_item_t feed_q[$];
  sorted_out_t sorted_expect[$];

  // Mirror of the sorted store
  logic signed [ValueW-1:0] held_vals [DEPTH];
  int unsigned              held_count     = 0;
  logic                     batch_overflow = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        in_xfer = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stable insertion: new value goes behind every held value <= it
  task automatic sort_insert(input logic signed [ValueW-1:0] v, input logic is_final);
    int pos;
    sorted_out_t res;
    if (held_count >= DEPTH) begin
      batch_overflow = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && held_vals[pos-1] > v) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
      end
      held_vals[pos] = v;
      held_count++;
    end
    if (is_final) begin
      for (int k = 0; k < held_count; k++) begin
        res.value      = held_vals[k];
        res.is_last    = (k + 1 == held_count);
        res.overflowed = batch_overflow;
        sorted_expect.push_back(res);
      end
      held_count     = 0;
      batch_overflow = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Input transfer: feed the predictor
  always @(posedge clk_i) begin
    in_xfer = rst_ni && in_valid_i && !in_stall_o;
    if (in_xfer) sort_insert(value_i, final_item_i);
  end

  // Output transfer: compare with the oldest expected result
  always @(posedge clk_i) begin : out_check
    sorted_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected result: sorted_value %0d", sorted_value_o);
        mismatches++;
      end else begin
        want = sorted_expect.pop_front();
        if (sorted_value_o !== want.value) begin
          $error("sorted_value: expected %0d, got %0d", want.value, sorted_value_o);
          mismatches++;
        end
        if (is_last_o !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, is_last_o);
          mismatches++;
        end
        if (overflowed_o !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed_o);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : feed_driver
    batch_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_xfer) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = feed_q.pop_front();
        in_valid_i   <= 1'b1;
        value_i      <= nxt.value;
        final_item_i <= nxt.is_final;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall; a hold request starts a long stretch counted here
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack    <= hold_req;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_item(input logic signed [ValueW-1:0] v, input logic is_final);
    batch_item_t it;
    it.value    = v;
    it.is_final = is_final;
    feed_q.push_back(it);
  endtask

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $signed($urandom_range(8)) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  // Mostly fitting batches, some that overflow the store
  task automatic add_batches(input int unsigned target);
    int unsigned added;
    int unsigned len;
    added = 0;
    while (added < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 4, DEPTH + 1)
                                     : $urandom_range(DEPTH, 1);
      for (int unsigned k = 0; k < len; k++) push_item(rand_value(), k + 1 == len);
      added += len;
    end
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    do @(posedge clk_i);
    while (feed_q.size() != 0 || in_valid_i || sorted_expect.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Single-value batch at the top of the range
    push_item(32'sh7FFF_FFFF, 1'b1);
    // Overfilled batch: extremes, duplicates, alternating bits; the last two
    // values are dropped, the final one included
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b0);
    push_item(5, 1'b0);
    push_item(5, 1'b0);
    push_item(-5, 1'b0);
    push_item(32'sh5555_5555, 1'b0);
    push_item(32'shAAAA_AAAA, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(7, 1'b0);
    push_item(-7, 1'b0);
    push_item(100, 1'b0);
    push_item(-100, 1'b0);
    push_item(3, 1'b0);
    push_item(42, 1'b1);
    // Flags must be clear again on the next batch
    push_item(-1, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(0, 1'b1);
    wait_drained();

    // No idling, with a long receiver hold while the sender keeps offering
    hold_req++;
    add_batches(24);
    wait_drained();

    send_idle_pct  = 69;
    recv_stall_pct = 0;
    add_batches(24);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 69;
    add_batches(24);
    wait_drained();

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    add_batches(24);
    wait_drained();

    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- insertion_sorter.f -----
rtl/ins_pkg.sv
rtl/ins_cell.sv
rtl/insertion_sorter.sv
rtl/ins_checker.sv
test/insertion_sorter_test.sv
